// ===== sv/bec_pkg.sv =====
// Shared types, constants and lookup functions of the batched elevator controller.
`default_nettype none

package bec_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int BUTTON_W  = 5;
    localparam int FLOOR_W   = 3;
    localparam int SEG_W     = 7;
    localparam int LAMP_W    = 5;
    localparam int PEND_W    = 3;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_FLOOR_COUNT = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL  = 2'd2;

    localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd6000;
    localparam logic [TICK_W-1:0] TRAVEL_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] DWELL_RESET  = 16'd3000;

    // Controller phase codes.
    localparam logic [1:0] PH_COLLECT = 2'd0;
    localparam logic [1:0] PH_TRAVEL  = 2'd1;
    localparam logic [1:0] PH_DWELL   = 2'd2;

    typedef logic [FLOOR_W-1:0] t_floor;

    typedef struct packed {
        logic [TICK_W-1:0] window_ticks;
        logic [TICK_W-1:0] travel_ticks;
        logic [TICK_W-1:0] dwell_ticks;
    } t_limits;

    typedef struct packed {
        t_floor            car;
        logic              going_up;
        logic              going_down;
        logic              collecting;
        logic [PEND_W-1:0] pending;
    } t_status;

    // Common-anode digit pattern, bit 0 is segment A, a low bit lights the segment.
    function automatic logic [SEG_W-1:0] digit_segments(input t_floor floor_num);
        logic [SEG_W-1:0] seg;
        case (floor_num)
            3'd1: seg = 7'h79;
            3'd2: seg = 7'h24;
            3'd3: seg = 7'h30;
            3'd4: seg = 7'h19;
            3'd5: seg = 7'h12;
            3'd6: seg = 7'h02;
            3'd7: seg = 7'h78;
            default: seg = 7'h7F;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bec_in_if.sv =====
// Input channel interface: one tick transaction carrying the sampled button levels.
`default_nettype none

interface bec_in_if;
    logic                          valid;
    logic                          ready;
    logic [bec_pkg::BUTTON_W-1:0]  button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

`default_nettype wire

// ===== sv/bec_out_if.sv =====
// Output channel interface: one status transaction per accepted tick.
`default_nettype none

interface bec_out_if;
    logic                          valid;
    logic                          ready;
    logic [bec_pkg::FLOOR_W-1:0]   shown_floor;
    logic                          going_up;
    logic                          going_down;
    logic [bec_pkg::SEG_W-1:0]     segment_levels;
    logic [bec_pkg::LAMP_W-1:0]    floor_lights;
    logic                          collecting;
    logic [bec_pkg::PEND_W-1:0]    pending_count;

    modport source (output valid, output shown_floor, output going_up, output going_down,
                    output segment_levels, output floor_lights, output collecting,
                    output pending_count, input ready);
    modport sink   (input valid, input shown_floor, input going_up, input going_down,
                    input segment_levels, input floor_lights, input collecting,
                    input pending_count, output ready);
endinterface

`default_nettype wire

// ===== sv/batched_elevator_controller.sv =====
// Top level of the batched elevator controller: configuration, handshake and result register.
//
// Usage:
//   i_req carries one transaction per time tick holding the active-low floor buttons.
//   o_rsp returns exactly one status transaction per accepted tick: car floor, direction
//   lights, seven-segment digit, one-hot floor lamp, window flag and queued request count,
//   all describing the state after that tick.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the window, travel
//   and dwell lengths in ticks; write it only while no transaction is in flight.
// Latency and throughput:
//   The status of a tick appears on o_rsp in the cycle after its acceptance, and one tick
//   is accepted every cycle unless o_rsp is held; the whole tick update is one pass of
//   logic between the state registers and the result register.
// Reset and stalls:
//   Reset opens a request window with an empty queue, the car at floor 1 and the
//   registers at 6000, 1000 and 3000 ticks. No clearing pass is needed.
//   While o_rsp is held, the result register keeps its transaction and i_req.ready
//   stays low until the result is taken; a new tick is accepted in that same cycle.
`default_nettype none

module batched_elevator_controller #(
    parameter int FLOOR_COUNT = bec_pkg::DEF_FLOOR_COUNT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    bec_in_if.sink                         i_req,
    bec_out_if.source                      o_rsp,
    input  wire                            i_cfg_we,
    input  wire [bec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bec_pkg::TICK_W-1:0]      i_cfg_data
);
    import bec_pkg::*;

    t_limits           r_limits;
    t_status           status;
    t_status           r_status;
    logic [SEG_W-1:0]  segments, r_segments;
    logic [LAMP_W-1:0] lights, r_lights;
    logic              r_out_valid, n_out_valid;
    logic              step;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign step        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.window_ticks <= WINDOW_RESET;
            r_limits.travel_ticks <= TRAVEL_RESET;
            r_limits.dwell_ticks  <= DWELL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW: r_limits.window_ticks <= i_cfg_data;
                REG_TRAVEL: r_limits.travel_ticks <= i_cfg_data;
                REG_DWELL:  r_limits.dwell_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bec_core #(
        .FLOOR_COUNT(FLOOR_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_buttons (i_req.button_levels),
        .i_limits  (r_limits),
        .o_status  (status)
    );

    bec_display u_display (
        .i_car      (status.car),
        .o_segments (segments),
        .o_lights   (lights)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status   <= status;
            r_segments <= segments;
            r_lights   <= lights;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.shown_floor    = r_status.car;
    assign o_rsp.going_up       = r_status.going_up;
    assign o_rsp.going_down     = r_status.going_down;
    assign o_rsp.segment_levels = r_segments;
    assign o_rsp.floor_lights   = r_lights;
    assign o_rsp.collecting     = r_status.collecting;
    assign o_rsp.pending_count  = r_status.pending;

endmodule

`default_nettype wire

// ===== sv/bec_core.sv =====
// Request queue, phase sequencer, tick counter and car position of the controller.
`default_nettype none

module bec_core #(
    parameter int FLOOR_COUNT = bec_pkg::DEF_FLOOR_COUNT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire [bec_pkg::BUTTON_W-1:0]  i_buttons,
    input  bec_pkg::t_limits             i_limits,
    output bec_pkg::t_status             o_status
);
    import bec_pkg::*;

    // Only floors that have both a button and a place in the car's range can be queued.
    localparam int QDEPTH = (FLOOR_COUNT < BUTTON_W) ? FLOOR_COUNT : BUTTON_W;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic [1:0]        r_phase, n_phase;
    t_floor            r_queue [QDEPTH];
    t_floor            n_queue [QDEPTH];
    logic [QDEPTH-1:0] r_queued, n_queued;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_serve, n_serve;
    t_floor            r_car, n_car;
    logic [TICK_W-1:0] r_tick, n_tick;

    logic [QDEPTH-1:0] new_req;
    t_floor            app_q [QDEPTH];
    t_floor            app_shift [QDEPTH];
    t_floor            cur_shift [QDEPTH];
    logic [CNT_W-1:0]  app_count;
    logic [CNT_W-1:0]  serve_inc;
    logic [TICK_W-1:0] tick_inc;
    logic              advance;

    // Append newly pressed floors in floor order behind the entries already held.
    always_comb begin
        new_req   = ~i_buttons[QDEPTH-1:0] & ~r_queued;
        app_q     = r_queue;
        app_count = r_count;
        for (int k = 0; k < QDEPTH; k++) begin
            if (new_req[k]) begin
                for (int j = 0; j < QDEPTH; j++) begin
                    if (app_count == CNT_W'(j)) begin
                        app_q[j] = FLOOR_W'(k + 1);
                    end
                end
                app_count = app_count + CNT_W'(1);
            end
        end
    end

    // The head of the queue is always the current target, so serving pops by shifting.
    always_comb begin
        for (int j = 0; j < QDEPTH - 1; j++) begin
            app_shift[j] = app_q[j + 1];
            cur_shift[j] = r_queue[j + 1];
        end
        app_shift[QDEPTH-1] = app_q[QDEPTH-1];
        cur_shift[QDEPTH-1] = r_queue[QDEPTH-1];
    end

    always_comb begin
        n_phase   = r_phase;
        n_queue   = r_queue;
        n_queued  = r_queued;
        n_count   = r_count;
        n_serve   = r_serve;
        n_car     = r_car;
        tick_inc  = r_tick + TICK_W'(1);
        n_tick    = tick_inc;
        serve_inc = r_serve + CNT_W'(1);
        advance   = 1'b0;

        case (r_phase)
            PH_COLLECT: begin
                n_queue  = app_q;
                n_count  = app_count;
                n_queued = r_queued | new_req;
                if (tick_inc >= i_limits.window_ticks) begin
                    n_tick = '0;
                    if (app_count != '0) begin
                        n_serve = '0;
                        n_phase = PH_TRAVEL;
                        // Queued floors are distinct, so at most one entry can match the car; only the head is checked.
                        if (app_q[0] == r_car) begin
                            if (app_count <= CNT_W'(1)) begin
                                n_count  = '0;
                                n_queued = '0;
                                n_phase  = PH_COLLECT;
                            end else begin
                                n_serve = CNT_W'(1);
                                n_queue = app_shift;
                            end
                        end
                    end
                end
            end
            PH_TRAVEL: begin
                if (tick_inc >= i_limits.travel_ticks) begin
                    n_tick = '0;
                    if (r_queue[0] > r_car) begin
                        n_car = r_car + FLOOR_W'(1);
                    end else if (r_queue[0] < r_car) begin
                        n_car = r_car - FLOOR_W'(1);
                    end
                end
                if (n_car == r_queue[0]) begin
                    n_tick = '0;
                    if (i_limits.dwell_ticks == '0) begin
                        advance = 1'b1;
                    end else begin
                        n_phase = PH_DWELL;
                    end
                end
            end
            PH_DWELL: begin
                if (tick_inc >= i_limits.dwell_ticks) begin
                    advance = 1'b1;
                end
            end
            default: begin
                n_phase = PH_COLLECT;
                n_tick  = '0;
            end
        endcase

        // Move to the next target; the next entry never equals the floor just reached.
        if (advance) begin
            n_tick = '0;
            if (serve_inc >= r_count) begin
                n_count  = '0;
                n_serve  = '0;
                n_queued = '0;
                n_phase  = PH_COLLECT;
            end else begin
                n_serve = serve_inc;
                n_queue = cur_shift;
                n_phase = PH_TRAVEL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COLLECT;
            r_queued <= '0;
            r_count  <= '0;
            r_serve  <= '0;
            r_car    <= FLOOR_W'(1);
            r_tick   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_queued <= n_queued;
            r_count  <= n_count;
            r_serve  <= n_serve;
            r_car    <= n_car;
            r_tick   <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_queue <= n_queue;
        end
    end

    // Status of the state after this tick, before the output register.
    always_comb begin
        o_status.car        = n_car;
        o_status.going_up   = (n_phase == PH_TRAVEL) && (n_queue[0] > n_car);
        o_status.going_down = (n_phase == PH_TRAVEL) && (n_queue[0] < n_car);
        o_status.collecting = (n_phase == PH_COLLECT);
        o_status.pending    = PEND_W'(n_count);
    end

endmodule

`default_nettype wire

// ===== sv/bec_display.sv =====
// Seven-segment and floor-lamp decoding of the car position.
`default_nettype none

module bec_display (
    input  bec_pkg::t_floor              i_car,
    output logic [bec_pkg::SEG_W-1:0]    o_segments,
    output logic [bec_pkg::LAMP_W-1:0]   o_lights
);
    import bec_pkg::*;

    always_comb begin
        o_segments = digit_segments(i_car);
        case (i_car)
            3'd1:    o_lights = 5'b00001;
            3'd2:    o_lights = 5'b00010;
            3'd3:    o_lights = 5'b00100;
            3'd4:    o_lights = 5'b01000;
            3'd5:    o_lights = 5'b10000;
            default: o_lights = 5'b00000;
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/tb_batched_elevator_controller.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the batched elevator controller with a tick-level car predictor.

module tb_batched_elevator_controller;
    import bec_pkg::*;

    localparam int FLOORS      = DEF_FLOOR_COUNT;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_PHASE  = 7;
    localparam int PLAN_N      = 9;

    // Common-anode digits 1 to 5, a low bit lights the segment.
    localparam logic [SEG_W-1:0] DIGIT_FONT [5] = '{7'h79, 7'h24, 7'h30, 7'h19, 7'h12};

    localparam logic [BUTTON_W-1:0] OPENING [4] = '{5'h1F, 5'h00, 5'h1E, 5'h1F};
    localparam logic [BUTTON_W-1:0] GUIDED [19] = '{
        5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1B, 5'h17, 5'h1F, 5'h1F,
        5'h1F, 5'h1F, 5'h0F, 5'h1E, 5'h1F, 5'h1D, 5'h1F, 5'h1F, 5'h1F
    };

    localparam int PLAN_WINDOW [PLAN_N] = '{8, 1, 0, 20, 65535, 1, 5, 6, 3};
    localparam int PLAN_TRAVEL [PLAN_N] = '{2, 1, 0, 3, 65535, 65535, 1, 2, 1};
    localparam int PLAN_DWELL  [PLAN_N] = '{3, 0, 0, 5, 65535, 2, 65535, 2, 1};
    localparam int PLAN_ITEMS  [PLAN_N] = '{250, 250, 200, 250, 30, 40, 60, 300, 250};
    localparam int PLAN_GAP    [PLAN_N] = '{0, 72, 0, 28, 0, 72, 0, 0, 28};
    localparam int PLAN_STALL  [PLAN_N] = '{0, 0, 72, 28, 0, 0, 72, 0, 28};

    typedef struct packed {
        t_floor              shown_floor;
        logic                going_up;
        logic                going_down;
        logic [SEG_W-1:0]    segment_levels;
        logic [LAMP_W-1:0]   floor_lights;
        logic                collecting;
        logic [PEND_W-1:0]   pending_count;
    } car_status_t;

    class CarStatusScoreboard;
        t_limits           limits;
        logic [1:0]        phase;
        t_floor            stops [FLOORS];
        int                stop_count;
        int                serve_pos;
        t_floor            car;
        logic [TICK_W-1:0] ticks;
        car_status_t       status_due [$];
        int                mismatches;

        function new();
            limits.window_ticks = WINDOW_RESET;
            limits.travel_ticks = TRAVEL_RESET;
            limits.dwell_ticks  = DWELL_RESET;
            phase = PH_COLLECT;
            foreach (stops[k]) stops[k] = '0;
            stop_count = 0;
            serve_pos  = 0;
            car        = 3'd1;
            ticks      = '0;
            mismatches = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
            case (idx)
                REG_WINDOW: limits.window_ticks = val;
                REG_TRAVEL: limits.travel_ticks = val;
                REG_DWELL:  limits.dwell_ticks  = val;
                default: ;
            endcase
        endfunction

        function bit idle();
            return status_due.size() == 0;
        endfunction

        function bit is_queued(t_floor fl);
            for (int k = 0; k < stop_count; k++) begin
                if (stops[k] == fl) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Targets at the car's floor are passed over at once; an exhausted queue reopens the window.
        function void next_target();
            while (serve_pos < stop_count && stops[serve_pos] == car) serve_pos++;
            ticks = '0;
            if (serve_pos >= stop_count) begin
                stop_count = 0;
                serve_pos  = 0;
                phase      = PH_COLLECT;
            end else begin
                phase = PH_TRAVEL;
            end
        endfunction

        function void note_tick(logic [BUTTON_W-1:0] buttons);
            t_floor      target;
            car_status_t s;
            case (phase)
                PH_COLLECT: begin
                    for (int k = 0; k < FLOORS; k++) begin
                        if (!buttons[k] && stop_count < FLOORS && !is_queued(t_floor'(k + 1))) begin
                            stops[stop_count] = t_floor'(k + 1);
                            stop_count++;
                        end
                    end
                    ticks = ticks + 1'b1;
                    if (ticks >= limits.window_ticks) begin
                        ticks = '0;
                        if (stop_count > 0) begin
                            serve_pos = 0;
                            next_target();
                        end
                    end
                end
                PH_TRAVEL: begin
                    target = stops[serve_pos];
                    ticks = ticks + 1'b1;
                    if (ticks >= limits.travel_ticks) begin
                        ticks = '0;
                        if (target > car) car = car + 1'b1;
                        else if (target < car) car = car - 1'b1;
                    end
                    if (car == target) begin
                        ticks = '0;
                        if (limits.dwell_ticks == '0) begin
                            serve_pos++;
                            next_target();
                        end else begin
                            phase = PH_DWELL;
                        end
                    end
                end
                PH_DWELL: begin
                    ticks = ticks + 1'b1;
                    if (ticks >= limits.dwell_ticks) begin
                        serve_pos++;
                        next_target();
                    end
                end
                default: begin
                    phase = PH_COLLECT;
                    ticks = '0;
                end
            endcase
            s.shown_floor    = car;
            s.going_up       = (phase == PH_TRAVEL) && (stops[serve_pos] > car);
            s.going_down     = (phase == PH_TRAVEL) && (stops[serve_pos] < car);
            s.segment_levels = (car >= 1 && car <= FLOORS) ? DIGIT_FONT[car - 1] : 7'h7F;
            s.floor_lights   = (car >= 1 && car <= FLOORS) ? 5'b00001 << (car - 1) : '0;
            s.collecting     = (phase == PH_COLLECT);
            s.pending_count  = PEND_W'(stop_count);
            status_due.push_back(s);
        endfunction

        function string show(car_status_t s);
            return $sformatf("floor=%0d up=%0b down=%0b seg=%02h lamps=%02h collect=%0b pend=%0d",
                             s.shown_floor, s.going_up, s.going_down, s.segment_levels,
                             s.floor_lights, s.collecting, s.pending_count);
        endfunction

        function void check_status(car_status_t got);
            car_status_t want;
            string       wrong;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: status transaction with none expected: %s", show(got));
                return;
            end
            want  = status_due.pop_front();
            wrong = "";
            if (got.shown_floor !== want.shown_floor)       wrong = {wrong, " shown_floor"};
            if (got.going_up !== want.going_up)             wrong = {wrong, " going_up"};
            if (got.going_down !== want.going_down)         wrong = {wrong, " going_down"};
            if (got.segment_levels !== want.segment_levels) wrong = {wrong, " segment_levels"};
            if (got.floor_lights !== want.floor_lights)     wrong = {wrong, " floor_lights"};
            if (got.collecting !== want.collecting)         wrong = {wrong, " collecting"};
            if (got.pending_count !== want.pending_count)   wrong = {wrong, " pending_count"};
            if (wrong != "") begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: status mismatch in%s", wrong);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    car_status_t        seen_status;
    CarStatusScoreboard board;

    bec_in_if  req_if ();
    bec_out_if rsp_if ();

    batched_elevator_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Inputs and results are both taken here so a tick is always noted before its status.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) board.note_tick(req_if.button_levels);
            if (rsp_if.valid && rsp_if.ready) begin
                seen_status.shown_floor    = rsp_if.shown_floor;
                seen_status.going_up       = rsp_if.going_up;
                seen_status.going_down     = rsp_if.going_down;
                seen_status.segment_levels = rsp_if.segment_levels;
                seen_status.floor_lights   = rsp_if.floor_lights;
                seen_status.collecting     = rsp_if.collecting;
                seen_status.pending_count  = rsp_if.pending_count;
                board.check_status(seen_status);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off each time the token moves.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_batched_elevator_controller: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [BUTTON_W-1:0] pick_buttons();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 5'h1F;
            5, 6:          return ~(5'b00001 << $urandom_range(FLOORS - 1));
            7:             return 5'h00;
            default:       return BUTTON_W'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic [BUTTON_W-1:0] buttons);
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.button_levels <= buttons;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (!board.idle());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= TICK_W'(val);
        @(posedge i_clk);
        board.set_limit(idx, TICK_W'(val));
    endtask

    task automatic write_limits(input int window, input int travel, input int dwell);
        wait_results();
        write_reg(REG_WINDOW, window);
        write_reg(REG_TRAVEL, travel);
        write_reg(REG_DWELL, dwell);
        cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_WINDOW;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.button_levels = '1;
        board                = new();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing first: all floors at once, then a press against the full queue.
        foreach (OPENING[k]) send_tick(OPENING[k]);
        // The window counter is already past the new limit, so serving starts on the next
        // tick, beginning with a target at the car's own floor and no dwell.
        write_limits(2, 1, 0);
        foreach (GUIDED[k]) send_tick(GUIDED[k]);

        for (int p = 0; p < PLAN_N; p++) begin
            write_limits(PLAN_WINDOW[p], PLAN_TRAVEL[p], PLAN_DWELL[p]);
            gap_pct   = PLAN_GAP[p];
            stall_pct = PLAN_STALL[p];
            for (int n = 0; n < PLAN_ITEMS[p]; n++) begin
                if (p == HOLD_PHASE && n == 50) hold_token <= hold_token + 1;
                if (p == HOLD_PHASE && n == 150) wait_results();
                send_tick(pick_buttons());
            end
        end

        wait_results();
        repeat (4) @(posedge i_clk);
        if (board.mismatches == 0 && board.idle())
            $display("tb_batched_elevator_controller: clean");
        else
            $display("tb_batched_elevator_controller: errors");
        $finish;
    end

endmodule
